### rtl/gse_pkg.sv
`default_nettype none
// ============================================================================
// gse_pkg
// Shared widths, luma weights, register indexes and pipeline tag types for
// the grayscale Sobel edge block.
// ============================================================================
package gse_pkg;

    // Pixel and configuration widths.
    localparam int PIX_W         = 8;
    localparam int CFG_W         = 12;
    localparam int CFG_IDX_W     = 1;
    localparam int ROW_W         = 11;
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int HEIGHT_LIMIT  = 2048;
    localparam int MIN_DIM       = 3;

    // Register reset values.
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    // Luma weights in unsigned Q0.16; they sum to 65536.
    localparam int WEIGHT_W = 16;
    localparam int PROD_W   = 24;
    localparam logic [WEIGHT_W-1:0] W_RED   = 16'd13933;
    localparam logic [WEIGHT_W-1:0] W_GREEN = 16'd46871;
    localparam logic [WEIGHT_W-1:0] W_BLUE  = 16'd4732;

    // Gradient and magnitude widths.
    localparam int GRAD_W = 11;
    localparam int MAG_W  = 12;
    localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    // Per-pixel flags that travel with a request down the pipeline.
    typedef struct packed {
        logic interior;
        logic row_end;
        logic frame_end;
    } t_tag;

endpackage
`default_nettype wire

### rtl/gse_pix_if.sv
`default_nettype none
// ============================================================================
// gse_pix_if
// Valid/ready channel that carries one RGB pixel per request.
// ============================================================================
interface gse_pix_if;
    import gse_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

### rtl/gse_res_if.sv
`default_nettype none
// ============================================================================
// gse_res_if
// Valid/ready channel that carries one edge magnitude with row and frame flags.
// ============================================================================
interface gse_res_if;
    import gse_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] edge_magnitude;
    logic             row_end;
    logic             frame_end;

    modport source (output valid, output edge_magnitude, output row_end, output frame_end,
                    input ready);
    modport sink   (input valid, input edge_magnitude, input row_end, input frame_end,
                    output ready);
endinterface
`default_nettype wire

### rtl/grayscale_sobel_edge.sv
`default_nettype none
// ============================================================================
// grayscale_sobel_edge
// RGB to gray conversion, two line stores and a 3x3 Sobel window with an L1
// magnitude, emitting results for interior pixels only.
// ============================================================================
// The block takes one RGB pixel per clock in raster order and sustains that
// rate as long as the result side keeps ready high. A pixel's result, if it
// has one, passes through the registered stages in order: products, line-store
// read and gray sum at the accepting edge, then the window, the gradients and
// the output register, from which it is presented on the result side.
// Each pixel reads both line stores at its column when accepted and
// writes them back when it moves into the window stage, which is the next edge
// unless the result side stalls, so every store sees at most one read and one
// write per clock on distinct columns. Pixels in the first two rows or first
// two columns of a frame give no result; a frame of W x H pixels yields
// (H-2) x (W-2) results, the last of each output row marked with row_end and
// the last of the frame also with frame_end. Writing frame_width or
// frame_height restarts the frame; do so only when the block is drained.
// Widths below 3 act as 3, widths above MAX_WIDTH as MAX_WIDTH, and heights
// are limited to 3..2048 the same way. There is no clearing pass after reset.
module grayscale_sobel_edge #(
    parameter int MAX_WIDTH = gse_pkg::MAX_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [gse_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gse_pkg::CFG_W-1:0]      i_cfg_data,
    gse_pix_if.sink                        i_pix,
    gse_res_if.source                      o_res
);
    import gse_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WCMP_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;

    // Configuration registers.
    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;

    // Frame geometry after clamping.
    logic [WCMP_W-1:0] w_ext;
    logic [WCMP_W-1:0] w_eff;
    logic [CFG_W-1:0]  h_eff;
    logic [COL_W-1:0]  col_last;
    logic [ROW_W-1:0]  row_last;

    // Position of the next input pixel.
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;

    // Pipeline flow control.
    logic pix_acc;
    logic load_b;
    logic load_c;
    logic load_d;
    logic load_out;
    logic b_move;

    // Stage B: products, column and tag, plus line-store read data.
    logic              r_b_valid;
    logic [COL_W-1:0]  r_b_col;
    t_tag              r_b_tag;
    logic [PROD_W-1:0] r_prod_red;
    logic [PROD_W-1:0] r_prod_green;
    logic [PROD_W-1:0] r_prod_blue;
    logic [PIX_W-1:0]  r_rd_upper;
    logic [PIX_W-1:0]  r_rd_middle;
    logic [PROD_W-1:0] gray_sum;
    logic [PIX_W-1:0]  gray;

    // Line stores.
    logic [PIX_W-1:0] mem_upper  [MAX_WIDTH];
    logic [PIX_W-1:0] mem_middle [MAX_WIDTH];

    // Stage C: the 3x3 window, top row first.
    logic             r_c_valid;
    t_tag             r_c_tag;
    logic [PIX_W-1:0] r_win [9];
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;

    // Stage D: gradients.
    logic                     r_d_valid;
    logic                     r_d_row_end;
    logic                     r_d_frame_end;
    logic signed [GRAD_W-1:0] r_d_gx;
    logic signed [GRAD_W-1:0] r_d_gy;
    logic [GRAD_W-1:0]        abs_x;
    logic [GRAD_W-1:0]        abs_y;
    logic [MAG_W-1:0]         mag_sum;
    logic [PIX_W-1:0]         mag_sat;

    // Output register.
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_mag;
    logic             r_out_row_end;
    logic             r_out_frame_end;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default:          r_frame_width  <= r_frame_width;
            endcase
        end
    end

    // Clamp the frame geometry and derive the last column and row.
    always_comb begin
        w_ext = WCMP_W'(r_frame_width);
        priority if (w_ext < WCMP_W'(MIN_DIM)) begin
            w_eff = WCMP_W'(MIN_DIM);
        end else if (w_ext > WCMP_W'(MAX_WIDTH)) begin
            w_eff = WCMP_W'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        priority if (r_frame_height < CFG_W'(MIN_DIM)) begin
            h_eff = CFG_W'(MIN_DIM);
        end else if (r_frame_height > CFG_W'(HEIGHT_LIMIT)) begin
            h_eff = CFG_W'(HEIGHT_LIMIT);
        end else begin
            h_eff = r_frame_height;
        end
        col_last = COL_W'(w_eff - WCMP_W'(1));
        row_last = ROW_W'(h_eff - CFG_W'(1));
    end

    // Ready ripples back from the output register through each stage.
    always_comb begin
        load_out = !r_out_valid || o_res.ready;
        load_d   = !r_d_valid || load_out;
        load_c   = !r_c_valid || load_d;
        load_b   = !r_b_valid || load_c;
        b_move   = r_b_valid && load_c;
        pix_acc  = i_pix.valid && load_b;
    end

    assign i_pix.ready = load_b;

    // Raster position update.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (pix_acc) begin
            if (r_col == col_last) begin
                n_col = '0;
                n_row = (r_row == row_last) ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Stage B capture: the three luma products and the pixel's flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (load_b) begin
            r_b_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_b_col            <= r_col;
            r_prod_red         <= PROD_W'(W_RED) * PROD_W'(i_pix.red);
            r_prod_green       <= PROD_W'(W_GREEN) * PROD_W'(i_pix.green);
            r_prod_blue        <= PROD_W'(W_BLUE) * PROD_W'(i_pix.blue);
            r_b_tag.interior   <= (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));
            r_b_tag.row_end    <= (r_col == col_last);
            r_b_tag.frame_end  <= (r_col == col_last) && (r_row == row_last);
        end
    end

    // Weighted sum cannot exceed 255 in the integer part.
    always_comb begin
        gray_sum = r_prod_red + r_prod_green + r_prod_blue;
        gray     = gray_sum[PROD_W-1 -: PIX_W];
    end

    // Line stores: read on accept, written back when the pixel leaves stage B.
    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_rd_upper <= mem_upper[r_col];
        end
        if (b_move) begin
            mem_upper[r_b_col] <= r_rd_middle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_rd_middle <= mem_middle[r_col];
        end
        if (b_move) begin
            mem_middle[r_b_col] <= gray;
        end
    end

    // Stage C: shift the window one column left and bring in the new column.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (load_c) begin
                r_c_valid <= r_b_valid;
            end
            if (b_move) begin
                for (int i = 0; i < 3; i++) begin
                    r_win[i*3 + 0] <= r_win[i*3 + 1];
                    r_win[i*3 + 1] <= r_win[i*3 + 2];
                end
                r_win[2] <= r_rd_upper;
                r_win[5] <= r_rd_middle;
                r_win[8] <= gray;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_move) begin
            r_c_tag <= r_b_tag;
        end
    end

    // Sobel kernels over the window.
    always_comb begin
        gx = (GRAD_W'(r_win[2]) + (GRAD_W'(r_win[5]) << 1) + GRAD_W'(r_win[8]))
           - (GRAD_W'(r_win[0]) + (GRAD_W'(r_win[3]) << 1) + GRAD_W'(r_win[6]));
        gy = (GRAD_W'(r_win[0]) + (GRAD_W'(r_win[1]) << 1) + GRAD_W'(r_win[2]))
           - (GRAD_W'(r_win[6]) + (GRAD_W'(r_win[7]) << 1) + GRAD_W'(r_win[8]));
    end

    // Stage D: only interior pixels go on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (load_d) begin
            r_d_valid <= r_c_valid && r_c_tag.interior;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_d && r_c_valid) begin
            r_d_gx        <= gx;
            r_d_gy        <= gy;
            r_d_row_end   <= r_c_tag.row_end;
            r_d_frame_end <= r_c_tag.frame_end;
        end
    end

    // L1 magnitude with saturation.
    always_comb begin
        abs_x   = (r_d_gx < 0) ? GRAD_W'(-r_d_gx) : GRAD_W'(r_d_gx);
        abs_y   = (r_d_gy < 0) ? GRAD_W'(-r_d_gy) : GRAD_W'(r_d_gy);
        mag_sum = MAG_W'(abs_x) + MAG_W'(abs_y);
        mag_sat = (mag_sum > MAG_W'(MAG_MAX)) ? MAG_MAX : mag_sum[PIX_W-1:0];
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out && r_d_valid) begin
            r_out_mag       <= mag_sat;
            r_out_row_end   <= r_d_row_end;
            r_out_frame_end <= r_d_frame_end;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.edge_magnitude = r_out_mag;
    assign o_res.row_end        = r_out_row_end;
    assign o_res.frame_end      = r_out_frame_end;

    // The input column never passes the last column of the clamped width.
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= col_last)
        else $error("column position beyond frame width");

    // A register write restarts the frame at its first pixel.
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> (r_col == '0) && (r_row == '0))
        else $error("register write did not restart the frame");

    // The frame's last result is always the last of its row.
    a_frame_end_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (!o_res.frame_end || o_res.row_end))
        else $error("frame end without row end");

endmodule
`default_nettype wire
